@@ rtl/core/status_led_pattern_generator_unit_macros.svh @@
// Assertion helpers for the status LED pattern generator.
`ifndef STATUS_LED_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SLPG_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slpg: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SLPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slpg: next-cycle check failed");

`endif

@@ rtl/core/slpg_pkg.sv @@
`timescale 1ns / 1ps

package slpg_pkg;

   typedef logic [3:0]  status_type;
   typedef logic [15:0] period_type;
   typedef logic [7:0]  level_type;

   // Status modes, numbered from 0 up to STATUS_LAST.
   localparam status_type STATUS_INIT          = 4'd0;
   localparam status_type STATUS_IO_ERROR      = 4'd1;
   localparam status_type STATUS_COMM_ERROR    = 4'd2;
   localparam status_type STATUS_WAITING_PAIR  = 4'd3;
   localparam status_type STATUS_PAIRED        = 4'd4;
   localparam status_type STATUS_CMD_RECEIVED  = 4'd5;
   localparam status_type STATUS_UNPAIRED      = 4'd6;
   localparam status_type STATUS_RESETTING     = 4'd7;
   localparam status_type STATUS_POWER_LOW     = 4'd8;
   localparam status_type STATUS_SHORT_CIRCUIT = 4'd9;
   localparam status_type STATUS_OVERCURRENT   = 4'd10;
   localparam status_type STATUS_HOT_POWER     = 4'd11;
   localparam status_type STATUS_HOT_LED1      = 4'd12;
   localparam status_type STATUS_HOT_LED2      = 4'd13;
   localparam status_type STATUS_LAST          = STATUS_HOT_LED2;

   // Word kinds on the request channel.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SET  = 1'b1;

   localparam period_type PERIOD_RESET = 16'd50;
   localparam period_type ELAPSED_MAX  = 16'hFFFF;

   // The step counter is kept as one phase counter per pattern period. All
   // periods divide 600, so the set of phases wraps exactly when the step would.
   typedef struct packed {
      logic [4:0] ph20;
      logic [4:0] ph30;
      logic [5:0] ph40;
      logic [5:0] ph60;
      logic [6:0] ph100;
   } phase_type;

   localparam logic [4:0] PH20_LAST  = 5'd19;
   localparam logic [4:0] PH30_LAST  = 5'd29;
   localparam logic [5:0] PH40_LAST  = 6'd39;
   localparam logic [5:0] PH60_LAST  = 6'd59;
   localparam logic [6:0] PH100_LAST = 7'd99;

   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } rgb_type;

   // Pattern tables, indexed by phase. Entries past a table's period are zero.
   localparam int unsigned LUT_DEPTH = 100;
   typedef logic [6:0] lut_index_type;
   typedef level_type lut_type [LUT_DEPTH];

   localparam int unsigned LUT_KIND_TRI20    = 0;
   localparam int unsigned LUT_KIND_COMM     = 1;
   localparam int unsigned LUT_KIND_TRI30    = 2;
   localparam int unsigned LUT_KIND_PAIRED   = 3;
   localparam int unsigned LUT_KIND_TRI15    = 4;
   localparam int unsigned LUT_KIND_OVER     = 5;
   localparam int unsigned LUT_KIND_RESET_R  = 6;
   localparam int unsigned LUT_KIND_RESET_G  = 7;

   function automatic lut_type make_lut(input int unsigned kind);
      lut_type     t;
      int unsigned c;
      int unsigned v;
      for (c = 0; c < LUT_DEPTH; c++) begin
         v = 0;
         case (kind)
            LUT_KIND_TRI20: begin
               if (c < 20) v = (c * 255) / 20;
               else if (c < 40) v = ((40 - c) * 255) / 20;
            end
            LUT_KIND_COMM: begin
               if (c < 10) v = (((c * 255) / 10) * 3) / 4;
               else if (c < 20) v = ((((20 - c) * 255) / 10) * 3) / 4;
            end
            LUT_KIND_TRI30: begin
               if (c < 30) v = (c * 255) / 30;
               else if (c < 60) v = ((60 - c) * 255) / 30;
            end
            LUT_KIND_PAIRED: begin
               if (c < 50) v = 128 + (c * 127) / 50;
               else v = 255 - ((c - 50) * 127) / 50;
            end
            LUT_KIND_TRI15: begin
               if (c < 15) v = (c * 255) / 15;
               else if (c < 30) v = ((30 - c) * 255) / 15;
            end
            LUT_KIND_OVER: begin
               if (c < 15) v = (((c * 255) / 15) * 3) / 4;
               else if (c < 30) v = ((((30 - c) * 255) / 15) * 3) / 4;
            end
            LUT_KIND_RESET_R: begin
               if (c < 10) v = 255;
               else if (c < 20) v = 255 - ((c * 6 - 60) * 255) / 60;
            end
            LUT_KIND_RESET_G: begin
               if (c < 10) v = (c * 6 * 255) / 60;
               else if (c < 20) v = 255;
            end
            default: v = 0;
         endcase
         t[c] = 8'(v);
      end
      return t;
   endfunction

   localparam lut_type LUT_TRI20   = make_lut(LUT_KIND_TRI20);
   localparam lut_type LUT_COMM    = make_lut(LUT_KIND_COMM);
   localparam lut_type LUT_TRI30   = make_lut(LUT_KIND_TRI30);
   localparam lut_type LUT_PAIRED  = make_lut(LUT_KIND_PAIRED);
   localparam lut_type LUT_TRI15   = make_lut(LUT_KIND_TRI15);
   localparam lut_type LUT_OVER    = make_lut(LUT_KIND_OVER);
   localparam lut_type LUT_RESET_R = make_lut(LUT_KIND_RESET_R);
   localparam lut_type LUT_RESET_G = make_lut(LUT_KIND_RESET_G);

endpackage

@@ rtl/core/slpg_if.sv @@
`timescale 1ns / 1ps

interface slpg_req_if;
   import slpg_pkg::*;
   logic       valid;
   logic       ready;
   logic       mode;
   status_type new_status;
   modport source (output valid, output mode, output new_status, input ready);
   modport sink   (input valid, input mode, input new_status, output ready);
endinterface

interface slpg_rsp_if;
   import slpg_pkg::*;
   logic      valid;
   logic      ready;
   level_type red;
   level_type green;
   level_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface slpg_csr_if;
   import slpg_pkg::*;
   logic       valid;
   logic       ready;
   period_type update_period;
   modport source (output valid, output update_period, input ready);
   modport sink   (input valid, input update_period, output ready);
endinterface

@@ rtl/core/slpg_color.sv @@
`timescale 1ns / 1ps

module slpg_color (
   input  slpg_pkg::status_type status,
   input  slpg_pkg::phase_type  phase,
   output slpg_pkg::rgb_type    rgb
);
   import slpg_pkg::*;

   lut_index_type idx20;
   lut_index_type idx30;
   lut_index_type idx40;
   lut_index_type idx60;
   lut_index_type idx100;
   level_type     tri40;

   assign idx20  = 7'(phase.ph20);
   assign idx30  = 7'(phase.ph30);
   assign idx40  = 7'(phase.ph40);
   assign idx60  = 7'(phase.ph60);
   assign idx100 = phase.ph100;
   assign tri40  = LUT_TRI20[idx40];

   always_comb begin
      rgb = '0;
      unique case (status)
         STATUS_INIT: begin
            rgb.green = LUT_TRI20[idx60];
            rgb.blue  = LUT_TRI20[idx60];
         end
         STATUS_IO_ERROR: begin
            if (phase.ph20 >= 5'd10) rgb.red = 8'd255;
         end
         STATUS_COMM_ERROR: begin
            if (phase.ph40 < 6'd20) begin
               rgb.red   = 8'd255;
               rgb.green = LUT_COMM[idx40];
            end
         end
         STATUS_WAITING_PAIR: rgb.blue = LUT_TRI30[idx60];
         STATUS_PAIRED:       rgb.green = LUT_PAIRED[idx100];
         STATUS_CMD_RECEIVED: begin
            if (phase.ph20 < 5'd4) rgb = '1;
         end
         STATUS_UNPAIRED: begin
            if (phase.ph40 < 6'd30) begin
               rgb.red   = 8'd255;
               rgb.green = LUT_TRI15[idx40];
            end
         end
         STATUS_RESETTING: begin
            rgb.red   = LUT_RESET_R[idx20];
            rgb.green = LUT_RESET_G[idx20];
         end
         STATUS_POWER_LOW: begin
            rgb.red   = tri40;
            rgb.green = tri40 >> 2;
         end
         STATUS_SHORT_CIRCUIT: begin
            // Toggles every two steps: bit one of the step.
            if (phase.ph20[1]) rgb.red = 8'd255;
         end
         STATUS_OVERCURRENT: begin
            rgb.red   = 8'd255;
            rgb.green = LUT_OVER[idx30];
         end
         STATUS_HOT_POWER: rgb.red = tri40;
         STATUS_HOT_LED1: begin
            if (phase.ph20 < 5'd10) begin
               rgb.red   = 8'd255;
               rgb.green = 8'd100;
            end else begin
               rgb.red   = 8'd200;
               rgb.green = 8'd50;
            end
         end
         STATUS_HOT_LED2: begin
            if (phase.ph20 < 5'd10) begin
               rgb.red  = 8'd150;
               rgb.blue = 8'd255;
            end else begin
               rgb.red  = 8'd100;
               rgb.blue = 8'd200;
            end
         end
         default: rgb = '0;
      endcase
   end

endmodule

@@ rtl/core/status_led_pattern_generator_unit.sv @@
`timescale 1ns / 1ps
// Channel    Dir   Payload                      Accepted when
// req_chan   in    mode, new_status             valid && ready
// rsp_chan   out   red, green, blue             valid && ready
// csr_chan   in    update_period                valid && ready (ready is always high)
//
// Every request word is handled in the cycle it is accepted; a tick that ends an
// update period registers its color word in the result register or the skid buffer.
// One request word per cycle is sustained; the result register plus a one-word
// skid buffer decouple the two sides, and req_chan.ready drops only while the skid
// buffer holds a word. Reset is synchronous and active high; it restores the init
// mode, clears the divider and the step phases and sets the period to 50.
module status_led_pattern_generator_unit (
   input  logic              clock,
   input  logic              reset,
   slpg_req_if.sink          req_chan,
   slpg_rsp_if.source        rsp_chan,
   slpg_csr_if.sink          csr_chan
);
   import slpg_pkg::*;

`include "status_led_pattern_generator_unit_macros.svh"

   // Pattern state. The animation step is carried as a set of phase counters,
   // one per pattern period, which is the step taken modulo each period.
   status_type status_ff, status_in;
   status_type prev_ff, prev_in;
   phase_type  phase_ff, phase_in;
   phase_type  phase_adv;
   period_type elapsed_ff, elapsed_in;
   period_type elapsed_inc;
   period_type period_ff, period_in;

   // Result register and skid buffer.
   logic       rsp_valid_ff, rsp_valid_in;
   rgb_type    rsp_data_ff, rsp_data_in;
   logic       skid_valid_ff, skid_valid_in;
   rgb_type    skid_data_ff, skid_data_in;

   logic       req_accept;
   logic       rsp_pop;
   logic       step_now;
   rgb_type    color;

   assign req_chan.ready = !skid_valid_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_pop        = rsp_valid_ff && rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = rsp_data_ff.red;
   assign rsp_chan.green = rsp_data_ff.green;
   assign rsp_chan.blue  = rsp_data_ff.blue;

   // The divider saturates rather than wrapping, so a very long period still ends.
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;

   // Phases one step ahead; the color of a step is taken at the new step.
   always_comb begin
      phase_adv.ph20  = (phase_ff.ph20  == PH20_LAST)  ? '0 : phase_ff.ph20  + 5'd1;
      phase_adv.ph30  = (phase_ff.ph30  == PH30_LAST)  ? '0 : phase_ff.ph30  + 5'd1;
      phase_adv.ph40  = (phase_ff.ph40  == PH40_LAST)  ? '0 : phase_ff.ph40  + 6'd1;
      phase_adv.ph60  = (phase_ff.ph60  == PH60_LAST)  ? '0 : phase_ff.ph60  + 6'd1;
      phase_adv.ph100 = (phase_ff.ph100 == PH100_LAST) ? '0 : phase_ff.ph100 + 7'd1;
   end

   slpg_color u_color (
      .status (status_ff),
      .phase  (phase_adv),
      .rgb    (color)
   );

   // Mode and step update for the accepted word.
   always_comb begin
      status_in  = status_ff;
      prev_in    = prev_ff;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      step_now   = 1'b0;
      if (req_accept) begin
         if (req_chan.mode == MODE_SET) begin
            // A set to an unknown mode, or to the mode already shown, is ignored.
            if (req_chan.new_status <= STATUS_LAST && req_chan.new_status != status_ff) begin
               prev_in   = status_ff;
               status_in = req_chan.new_status;
               phase_in  = '0;
            end
         end else if (elapsed_inc >= period_ff) begin
            // A zero period, or one lowered below the count, steps at once.
            elapsed_in = '0;
            step_now   = 1'b1;
            phase_in   = phase_adv;
            // The command flash shows its last (dark) step, then falls back to
            // the mode it interrupted.
            if (status_ff == STATUS_CMD_RECEIVED && phase_adv.ph20 == PH20_LAST &&
                prev_ff != status_ff) begin
               prev_in   = status_ff;
               status_in = prev_ff;
               phase_in  = '0;
            end
         end else begin
            elapsed_in = elapsed_inc;
         end
      end
   end

   assign period_in = csr_chan.valid ? csr_chan.update_period : period_ff;

   // Output side: a new color goes to the result register when it is free or
   // being drained, and to the skid buffer otherwise.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (step_now) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = color;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = color;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= STATUS_INIT;
         prev_ff       <= STATUS_INIT;
         phase_ff      <= '0;
         elapsed_ff    <= '0;
         period_ff     <= PERIOD_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         status_ff     <= status_in;
         prev_ff       <= prev_in;
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         period_ff     <= period_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid buffer only ever backs up an occupied result register.
   `SLPG_ASSERT_IMPLIES(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)
   // Any change of mode restarts the animation from step zero.
   `SLPG_ASSERT_IMPLIES(a_mode_change_clears_phase, clock, reset, !$stable(status_ff), phase_ff == '0)
   // A step always leaves a result waiting on the next cycle.
   `SLPG_ASSERT_NEXT(a_step_gives_result, clock, reset, step_now, rsp_valid_ff)

endmodule
